// ===== src/uas_pkg.sv =====
// Shared types and constants for the upwind advection stencil.
// No dependencies.
package uas_pkg;
	localparam int CW = 18;
	localparam int NW = 7;
	typedef enum logic [2:0] {
		REG_CX = 3'd0, REG_CY = 3'd1, REG_CZ = 3'd2,
		REG_NX = 3'd3, REG_NY = 3'd4, REG_NZ = 3'd5
	} reg_idx_t;
	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
	} courant_t;
endpackage

// ===== src/uas_stream_if.sv =====
// Valid/ready stream channel carrying a sample and a marker bit.
// No dependencies.
interface uas_stream_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] data;
	logic mark;
	modport source (output valid, data, mark, input ready);
	modport sink (input valid, data, mark, output ready);
endinterface

// ===== src/uas_cell.sv =====
// One delay cell of the neighbor chain: a register that hands its value on.
// Depends on nothing.
module uas_cell #(parameter int W = 32) (
	input  logic clk,
	input  logic en,
	input  logic signed [W-1:0] d,
	output logic signed [W-1:0] q
);
	logic signed [W-1:0] v_q;
	always_ff @(posedge clk) begin
		if (en) v_q <= d;
	end
	assign q = v_q;
endmodule

// ===== src/uas_line.sv =====
// Delay line held in a memory: each enable writes one item and reads the one len items older.
// Depends on nothing; the len input sets the delay, 1 to DEPTH items.
module uas_line #(parameter int W = 32, parameter int DEPTH = 8712) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [$clog2(DEPTH+1)-1:0] len,
	input  logic signed [W-1:0] d,
	output logic signed [W-1:0] q
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic signed [W-1:0] mem [DEPTH];
	logic [AW-1:0] ptr_q;
	logic signed [W-1:0] rd_q;
	logic [AW:0] ptr_inc;
	logic [AW:0] len_ext;
	assign ptr_inc = {1'b0, ptr_q} + 1'b1;
	assign len_ext = (AW+1)'(len);
	// read-before-write: data read at ptr is len items old when ptr wraps at len
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= mem[ptr_q];
			mem[ptr_q] <= d;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ptr_q <= '0;
		else if (en) begin
			if (ptr_inc >= len_ext) ptr_q <= '0;
			else ptr_q <= ptr_inc[AW-1:0];
		end
	end
	assign q = rd_q;
endmodule

// ===== src/upwind_advection_stencil_3d.sv =====
// Upwind advection stencil over a streamed, halo-padded 3D grid.
// A result passes through the window flag, stage 1, stage 2 and the output register after the accept of the item
// that completes its cell (the sample one plane above it).
// Throughput: one item per cycle; a result waiting at the output holds the input ready low.
// Reset clears positions, configuration registers and valid flags; the delay lines hold undefined data until filled.
// Depends on uas_pkg, uas_stream_if, uas_cell, uas_line.
module upwind_advection_stencil_3d #(
	parameter int MAX_X = 64, parameter int MAX_Y = 64,
	parameter int MAX_Z = 64, parameter int SAMPLE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	uas_stream_if.sink in_s,
	uas_stream_if.source out_s,
	input  logic psel, input logic penable, input logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import uas_pkg::*;
	localparam int W = SAMPLE_WIDTH;
	localparam int PX = MAX_X + 2;
	localparam int PLANE = PX * (MAX_Y + 2);
	localparam int LW = $clog2(PLANE + 1);
	localparam int PW = $clog2(PX + 1) + 1;
	localparam int QW = $clog2(MAX_Z + 3) + 1;
	localparam int YW = $clog2(MAX_Y + 3) + 1;
	localparam int AW = W + 16 + 4;
	localparam int PRW = CW + W + 1;
	localparam int DA = PLANE - PX;
	localparam int DZ = PLANE - PX - 1;
	localparam int DX = MAX_X;
	localparam int DY = MAX_X + 1;
	localparam int LA = $clog2(DA + 1);
	localparam int LZ = $clog2(DZ + 1);
	localparam int LX = $clog2(DX + 1);
	localparam int LY = $clog2(DY + 1);
	localparam logic signed [AW-1:0] LIM_HI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [AW-1:0] LIM_LO = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};

	courant_t cr_q;
	logic [NW-1:0] nxr_q, nyr_q, nzr_q;
	logic [PW-1:0] nx; logic [YW-1:0] ny; logic [QW-1:0] nz;
	assign pready = 1'b1;
	wire wr = psel & penable & pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q <= '0; nxr_q <= 7'd64; nyr_q <= 7'd64; nzr_q <= 7'd64;
		end else if (wr) begin
			case (paddr[4:2])
				REG_CX: cr_q.cx <= pwdata[CW-1:0];
				REG_CY: cr_q.cy <= pwdata[CW-1:0];
				REG_CZ: cr_q.cz <= pwdata[CW-1:0];
				REG_NX: nxr_q <= pwdata[NW-1:0];
				REG_NY: nyr_q <= pwdata[NW-1:0];
				REG_NZ: nzr_q <= pwdata[NW-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[4:2])
			REG_CX: prdata = 32'(signed'(cr_q.cx));
			REG_CY: prdata = 32'(signed'(cr_q.cy));
			REG_CZ: prdata = 32'(signed'(cr_q.cz));
			REG_NX: prdata = 32'(nxr_q);
			REG_NY: prdata = 32'(nyr_q);
			REG_NZ: prdata = 32'(nzr_q);
			default: prdata = '0;
		endcase
	end
	always_comb begin
		nx = (nxr_q == 0) ? PW'(1) : (32'(nxr_q) > MAX_X) ? PW'(MAX_X) : PW'(nxr_q);
		ny = (nyr_q == 0) ? YW'(1) : (32'(nyr_q) > MAX_Y) ? YW'(MAX_Y) : YW'(nyr_q);
		nz = (nzr_q == 0) ? QW'(1) : (32'(nzr_q) > MAX_Z) ? QW'(MAX_Z) : QW'(nzr_q);
	end

	// stall the whole pipe when the output register is full and not taken
	logic v_s1, v_s2, v_s3, l_s1, l_s2;
	wire adv = !out_s.valid || out_s.ready;
	assign in_s.ready = adv;
	wire acc = in_s.valid & adv;

	logic [PW-1:0] px_q; logic [YW-1:0] py_q; logic [QW-1:0] pz_q;
	logic [PW-1:0] x, x_nx; logic [YW-1:0] y, y_nx; logic [QW-1:0] z, z_nx;
	always_comb begin
		x = in_s.mark ? '0 : px_q; y = in_s.mark ? '0 : py_q; z = in_s.mark ? '0 : pz_q;
		x_nx = x + 1'b1; y_nx = y; z_nx = z;
		if (x + 1'b1 >= nx + 2'd2) begin
			x_nx = '0;
			if (y + 1'b1 >= ny + 2'd2) begin
				y_nx = '0;
				z_nx = (z + 1'b1 >= nz + 2'd2) ? '0 : z + 1'b1;
			end else y_nx = y + 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin px_q <= '0; py_q <= '0; pz_q <= '0; end
		else if (acc) begin
			px_q <= x_nx; py_q <= y_nx; pz_q <= z_nx;
		end
	end

	// item (x,y,z) completes cell (x,y,z-1); taps are lags in items behind it
	logic [LW-1:0] rlen, plen;
	assign rlen = LW'(nx) + LW'(2);
	assign plen = LW'(32'(rlen) * (32'(ny) + 32'd2));
	wire [LA-1:0] len_a = LA'(plen - rlen);
	wire [LX-1:0] len_x = LX'(nx);
	wire [LY-1:0] len_y = LY'(nx + 1'b1);
	wire [LZ-1:0] len_z = LZ'(plen - rlen - 1'b1);

	// lags: zp 0, yp plane-row, xp plane-1, u plane, xm plane+1, ym plane+row, zm 2 planes
	logic signed [W-1:0] t_zp, t_yp, t_xp, t_u, t_xm, t_ym, t_zm;
	uas_cell #(.W(W)) u_czp (.clk, .en(acc), .d(in_s.data), .q(t_zp));
	uas_line #(.W(W), .DEPTH(DA)) u_lyp (.clk, .arst_n, .en(acc),
		.len(len_a), .d(in_s.data), .q(t_yp));
	uas_line #(.W(W), .DEPTH(DX)) u_lxp (.clk, .arst_n, .en(acc),
		.len(len_x), .d(t_yp), .q(t_xp));
	uas_cell #(.W(W)) u_cu (.clk, .en(acc), .d(t_xp), .q(t_u));
	uas_cell #(.W(W)) u_cxm (.clk, .en(acc), .d(t_u), .q(t_xm));
	uas_line #(.W(W), .DEPTH(DY)) u_lym (.clk, .arst_n, .en(acc),
		.len(len_y), .d(t_u), .q(t_ym));
	uas_line #(.W(W), .DEPTH(DZ)) u_lzm (.clk, .arst_n, .en(acc),
		.len(len_z), .d(t_ym), .q(t_zm));

	logic emit_k, last_k;
	assign emit_k = x >= PW'(1) && x <= nx && y >= YW'(1) && y <= ny
		&& z >= QW'(2) && z <= nz + QW'(1);
	assign last_k = x == nx && y == ny && z == nz + QW'(1);
	// window flag: set by the item that completes a cell, cleared once stage 1 takes it
	logic win_v_q, win_l_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin win_v_q <= 1'b0; win_l_q <= 1'b0; end
		else if (acc) begin win_v_q <= emit_k; win_l_q <= last_k; end
		else if (adv) win_v_q <= 1'b0;
	end

	// stage 1: differences with upwind choice
	logic signed [W:0] dx_s1, dy_s1, dz_s1;
	logic signed [W-1:0] u_s1;
	courant_t c_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= t_u; c_s1 <= cr_q;
			dx_s1 <= cr_q.cx[CW-1] ? (W+1)'(t_xp) - (W+1)'(t_u) : (W+1)'(t_u) - (W+1)'(t_xm);
			dy_s1 <= cr_q.cy[CW-1] ? (W+1)'(t_yp) - (W+1)'(t_u) : (W+1)'(t_u) - (W+1)'(t_ym);
			dz_s1 <= cr_q.cz[CW-1] ? (W+1)'(t_zp) - (W+1)'(t_u) : (W+1)'(t_u) - (W+1)'(t_zm);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; l_s1 <= 1'b0; l_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= win_v_q; l_s1 <= win_l_q;
			v_s2 <= v_s1; l_s2 <= l_s1;
		end
	end
	// stage 2: products
	logic signed [PRW-1:0] px_s2, py_s2, pz_s2;
	logic signed [AW-1:0] u_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= c_s1.cx * dx_s1;
			py_s2 <= c_s1.cy * dy_s1;
			pz_s2 <= c_s1.cz * dz_s1;
			u_s2 <= AW'(u_s1) <<< 16;
		end
	end
	// stage 3: sum, round, saturate
	logic signed [AW-1:0] sum, q;
	logic signed [W-1:0] r;
	always_comb begin
		sum = u_s2 - AW'(px_s2) - AW'(py_s2) - AW'(pz_s2) + AW'(32768);
		q = sum >>> 16;
		if (q > LIM_HI) r = {1'b0, {(W-1){1'b1}}};
		else if (q < LIM_LO) r = {1'b1, {(W-1){1'b0}}};
		else r = q[W-1:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin out_s.data <= r; out_s.mark <= l_s2; end
	end
	assign out_s.valid = v_s3;

	property p_stall_hold;
		@(posedge clk) disable iff (!arst_n) out_s.valid && !out_s.ready |=>
			$stable(out_s.data) && $stable(out_s.mark);
	endproperty
	a_hold: assert property (p_stall_hold) else $error("result changed under stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_s.valid && !out_s.ready |-> !in_s.ready) else $error("accept while stalled");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !in_s.mark && px_q < nx + 2'd1 |=> px_q == $past(px_q) + 1'b1)
		else $error("x counter slip");
endmodule

// ===== sim/upwind_advection_stencil_3d_tb.sv =====
// Self-checking bench for upwind_advection_stencil_3d: streams padded grids,
// predicts every interior cell update and compares the output stream.
// Depends on uas_pkg, uas_stream_if and the stencil RTL.
module upwind_advection_stencil_3d_tb;
	import uas_pkg::*;

	localparam int MAXC = 64;
	localparam int PADC = MAXC + 2;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	uas_stream_if #(.W(32)) in_if ();
	uas_stream_if #(.W(32)) out_if ();

	upwind_advection_stencil_3d u_top (
		.clk(clk), .arst_n(arst_n),
		.in_s(in_if.sink), .out_s(out_if.source),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// predictor state
	logic signed [CW-1:0] cfg_cx, cfg_cy, cfg_cz;
	logic [NW-1:0] cfg_nx, cfg_ny, cfg_nz;
	logic signed [31:0] window [2][PADC][PADC];
	int pos_x, pos_y, pos_z;
	cell_t pending_cells [$];

	int errors = 0;
	int sent = 0;
	int stall_cycles = 0;
	bit no_idle = 1'b0;
	bit grid_done = 1'b0;

	initial begin
		in_if.valid = 1'b0;
		in_if.data = '0;
		in_if.mark = 1'b0;
		out_if.ready = 1'b0;
	end

	function automatic int clamp_cells(logic [NW-1:0] v);
		if (v < 1) return 1;
		if (v > MAXC) return MAXC;
		return int'(v);
	endfunction

	function automatic longint upwind_term(longint c, longint u, longint lo, longint hi);
		return (c >= 0) ? c * (u - lo) : c * (hi - u);
	endfunction

	// advance the grid position by one sample and queue the interior cell it completes, if any
	function automatic void advance_grid(logic signed [31:0] s, logic start);
		int nx, ny, nz, x, y, z, pc, pp;
		longint u, acc, q;
		cell_t c;
		nx = clamp_cells(cfg_nx);
		ny = clamp_cells(cfg_ny);
		nz = clamp_cells(cfg_nz);
		if (start) begin
			pos_x = 0; pos_y = 0; pos_z = 0;
		end
		x = pos_x; y = pos_y; z = pos_z;
		pc = z & 1;
		pp = pc ^ 1;
		if (x >= 1 && x <= nx && y >= 1 && y <= ny && z >= 2 && z <= nz + 1) begin
			u = window[pp][y][x];
			acc = u * 65536;
			acc -= upwind_term(cfg_cx, u, window[pp][y][x-1], window[pp][y][x+1]);
			acc -= upwind_term(cfg_cy, u, window[pp][y-1][x], window[pp][y+1][x]);
			acc -= upwind_term(cfg_cz, u, window[pc][y][x], s);
			acc += 32768;
			q = acc >>> 16;
			if (q > 64'sd2147483647) q = 64'sd2147483647;
			if (q < -64'sd2147483648) q = -64'sd2147483648;
			c.value = q[31:0];
			c.last = (x == nx && y == ny && z == nz + 1);
			pending_cells.push_back(c);
		end
		if (y < PADC && x < PADC) window[pc][y][x] = s;
		x++;
		if (x >= nx + 2) begin
			x = 0; y++;
			if (y >= ny + 2) begin
				y = 0; z++;
				if (z >= nz + 2) z = 0;
			end
		end
		pos_x = x; pos_y = y; pos_z = z;
	endfunction

	// called at a rising edge, returns at the edge that accepted the item
	task automatic send_item(logic signed [31:0] s, logic start);
		int gap;
		bit took;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= s;
		in_if.mark <= start;
		do begin
			@(negedge clk);
			took = in_if.ready;
			@(posedge clk);
		end while (!took);
		advance_grid(s, start);
		sent++;
	endtask

	task automatic wait_idle();
		in_if.valid <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_CX: cfg_cx = value[CW-1:0];
			REG_CY: cfg_cy = value[CW-1:0];
			REG_CZ: cfg_cz = value[CW-1:0];
			REG_NX: cfg_nx = value[NW-1:0];
			REG_NY: cfg_ny = value[NW-1:0];
			REG_NZ: cfg_nz = value[NW-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int cx, int cy, int cz, int nx, int ny, int nz);
		wait_idle();
		apb_write(REG_CX, cx);
		apb_write(REG_CY, cy);
		apb_write(REG_CZ, cz);
		apb_write(REG_NX, nx);
		apb_write(REG_NY, ny);
		apb_write(REG_NZ, nz);
		grid_done = 1'b0;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 65535) - 32768;
			3: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_courant();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 65536;
			2: return -65536;
			3: return 131071;
			4: return -131072;
			default: return $urandom_range(0, 131072) - 65536;
		endcase
	endfunction

	// one padded grid; a truncated grid leaves the next one to need a start mark
	task automatic send_grid(bit truncate);
		int total, stop;
		total = (clamp_cells(cfg_nx) + 2) * (clamp_cells(cfg_ny) + 2)
			* (clamp_cells(cfg_nz) + 2);
		stop = truncate ? $urandom_range(1, total - 1) : total;
		for (int i = 0; i < stop; i++)
			send_item(rand_sample(), i == 0 && (!grid_done || $urandom_range(0, 1)));
		grid_done = !truncate;
	endtask

	task automatic test_directed();
		logic [31:0] vals [5];
		vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_8000};
		set_config(65536, -65536, 0, 1, 1, 1);
		for (int i = 0; i < 27; i++)
			send_item(vals[i % 5] ^ ((i == 13) ? 32'h5555_5555 : 32'h0), i == 0);
		grid_done = 1'b1;
		// next grid with its start mark left to chance, Courant extremes of both signs
		set_config(-131072, 131071, -65536, 1, 1, 1);
		grid_done = 1'b1;
		send_grid(1'b0);
	endtask

	task automatic test_extent_limits();
		// zero cells behaves as one, oversized counts clamp to the maximum
		set_config(rand_courant(), rand_courant(), rand_courant(), 127, 0, 0);
		send_grid(1'b0);
		set_config(rand_courant(), rand_courant(), rand_courant(), 1, 64, 1);
		send_grid(1'b0);
		set_config(rand_courant(), rand_courant(), rand_courant(), 0, 1, 64);
		send_grid(1'b0);
	endtask

	task automatic test_random_grids();
		int ngrids;
		while (sent < 2000) begin
			no_idle = ($urandom_range(0, 4) == 0);
			set_config(rand_courant(), rand_courant(), rand_courant(),
				$urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5));
			ngrids = $urandom_range(1, 3);
			for (int g = 0; g < ngrids; g++)
				send_grid($urandom_range(0, 9) == 0);
		end
		no_idle = 1'b0;
	endtask

	// result side: random stalls, compare against the oldest prediction
	initial begin
		int w;
		bit took;
		cell_t exp_c;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 10);
			if (w > 0) begin
				out_if.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_if.valid;
				if (took) begin
					if (pending_cells.size() == 0) begin
						$error("unexpected result new_value=%0h", out_if.data);
						errors++;
					end else begin
						exp_c = pending_cells.pop_front();
						if (out_if.data !== exp_c.value) begin
							$error("new_value expected %0h got %0h", exp_c.value, out_if.data);
							errors++;
						end
						if (out_if.mark !== exp_c.last) begin
							$error("grid_last expected %0b got %0b", exp_c.last, out_if.mark);
							errors++;
						end
					end
				end
				@(posedge clk);
			end while (!took);
		end
	end

	always @(negedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("upwind_advection_stencil_3d: mismatch");
			$finish;
		end
	end

	initial begin
		cfg_cx = '0; cfg_cy = '0; cfg_cz = '0;
		cfg_nx = 7'd64; cfg_ny = 7'd64; cfg_nz = 7'd64;
		pos_x = 0; pos_y = 0; pos_z = 0;
		foreach (window[p, y, x]) window[p][y][x] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extent_limits();
		test_random_grids();
		wait_idle();
		if (errors == 0 && pending_cells.size() == 0)
			$display("upwind_advection_stencil_3d: match");
		else
			$display("upwind_advection_stencil_3d: mismatch");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/uas_pkg.sv
src/uas_stream_if.sv
src/uas_cell.sv
src/uas_line.sv
src/upwind_advection_stencil_3d.sv
sim/upwind_advection_stencil_3d_tb.sv
